// ===== hw/rtl/cshr_pkg.sv =====
package cshr_pkg;

   typedef enum logic [1:0] {
      OP_FILL = 2'd0,
      OP_RING = 2'd1,
      OP_LINE = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef struct packed {
      op_type             opcode;
      logic signed [11:0] x_a;
      logic signed [11:0] y_a;
      logic signed [11:0] x_b;
      logic signed [11:0] y_b;
      logic        [10:0] radius;
      logic        [7:0]  symbol;
      logic        [5:0]  pixel_col;
      logic        [4:0]  pixel_row;
   } req_type;

   typedef struct packed {
      logic       is_read;
      logic [7:0] pixel_symbol;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_DONE,
      ST_READ
   } state_type;

   // one product per setup step but the last, registered in prod_ff and used by the next step
   typedef enum logic [2:0] {
      SU_XA2,
      SU_YA2,
      SU_OUTER,
      SU_INNER,
      SU_XAYB,
      SU_XBYA,
      SU_LAST
   } setup_type;

   localparam int ACC_W = 32;   // Q.8 accumulators
   localparam int OFS_W = 14;   // Q.4 pixel offsets
   localparam int MUL_W = 13;   // setup multiplier operands

   localparam logic signed [ACC_W-1:0] UNIT_SQ = ACC_W'(256);
   localparam logic signed [ACC_W-1:0] LINE_LIM = ACC_W'(256);

endpackage

// ===== hw/rtl/canvas_shape_rasterizer.sv =====
// Draw command: setup steps SU_XA2 to SU_LAST on one shared multiplier, then one
// memory write slot per canvas pixel, then the done word; one command at a time.
// Read command: result in the cycle after accept (one registered memory read).
// Reset (synchronous) starts a clearing pass over every canvas word with busy high.
// The receiver cannot stall: each result word shows for one cycle on rsp_strobe.
module canvas_shape_rasterizer
   import cshr_pkg::*;
#(
   parameter int CANVAS_WIDTH  = 64,
   parameter int CANVAS_HEIGHT = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   localparam int DEPTH  = CANVAS_WIDTH * CANVAS_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COL_W  = (CANVAS_WIDTH > 1) ? $clog2(CANVAS_WIDTH) : 1;
   localparam int ROW_W  = (CANVAS_HEIGHT > 1) ? $clog2(CANVAS_HEIGHT) : 1;

   logic [7:0] canvas_mem [DEPTH];

   state_type               state_ff, state_in;
   setup_type               step_ff, step_in;
   req_type                 cmd_ff, cmd_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic signed [2*MUL_W-1:0] prod_ff, prod_in;
   logic signed [OFS_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [ACC_W-1:0] d_ff, d_in, drow_ff, drow_in;
   logic signed [ACC_W-1:0] outer_ff, outer_in, inner_ff, inner_in;
   logic signed [ACC_W-1:0] s_ff, s_in, srow_ff, srow_in;
   logic signed [ACC_W-1:0] a16_ff, a16_in, b16_ff, b16_in;
   logic signed [OFS_W-1:0] x_lo_ff, x_lo_in, x_hi_ff, x_hi_in;
   logic signed [OFS_W-1:0] y_lo_ff, y_lo_in, y_hi_ff, y_hi_in;
   logic [7:0]              rd_data_ff;

   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [OFS_W-1:0] px, py;
   logic signed [ACC_W-1:0] drow_next, srow_next;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    accept, covered, last_col, last_row, mem_we;
   logic [7:0]              mem_wdata;

   assign accept   = start && !busy;
   assign px       = signed'(OFS_W'({col_ff, 4'b0000}));
   assign py       = signed'(OFS_W'({row_ff, 4'b0000}));
   assign last_col = (col_ff == COL_W'(CANVAS_WIDTH - 1));
   assign last_row = (row_ff == ROW_W'(CANVAS_HEIGHT - 1));
   assign rd_addr  = ADDR_W'(32'(req_word.pixel_row) * CANVAS_WIDTH
                             + 32'(req_word.pixel_col));

   assign drow_next = drow_ff + (ACC_W'(dy_ff) <<< 5) + UNIT_SQ;
   assign srow_next = srow_ff + b16_ff;

   always_comb begin
      if (cmd_ff.opcode == OP_LINE) begin
         covered = (s_ff > -LINE_LIM) && (s_ff < LINE_LIM)
                   && (px >= x_lo_ff) && (px <= x_hi_ff)
                   && (py >= y_lo_ff) && (py <= y_hi_ff);
      end else begin
         covered = (d_ff < outer_ff) && ((cmd_ff.opcode == OP_FILL) || (d_ff > inner_ff));
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd_in    = cmd_ff;
      rd_ok_in  = rd_ok_ff;
      addr_in   = addr_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      d_in      = d_ff;
      drow_in   = drow_ff;
      outer_in  = outer_ff;
      inner_in  = inner_ff;
      s_in      = s_ff;
      srow_in   = srow_ff;
      a16_in    = a16_ff;
      b16_in    = b16_ff;
      x_lo_in   = x_lo_ff;
      x_hi_in   = x_hi_ff;
      y_lo_in   = y_lo_ff;
      y_hi_in   = y_hi_ff;
      mul_a     = '0;
      mul_b     = '0;
      mem_we    = 1'b0;
      mem_wdata = cmd_ff.symbol;
      rsp_strobe           = 1'b0;
      rsp_word.is_read     = 1'b0;
      rsp_word.pixel_symbol = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            addr_in   = addr_ff + 1'b1;
            if (addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_word;
               rd_ok_in = (32'(req_word.pixel_col) < CANVAS_WIDTH)
                          && (32'(req_word.pixel_row) < CANVAS_HEIGHT);
               step_in  = SU_XA2;
               state_in = (req_word.opcode == OP_READ) ? ST_READ : ST_SETUP;
            end
         end
         ST_SETUP: begin
            unique case (step_ff)
               SU_XA2: begin
                  mul_a   = MUL_W'(cmd_ff.x_a);
                  mul_b   = MUL_W'(cmd_ff.x_a);
                  dx_in   = -OFS_W'(cmd_ff.x_a);
                  dy_in   = -OFS_W'(cmd_ff.y_a);
                  a16_in  = (ACC_W'(cmd_ff.y_a) - ACC_W'(cmd_ff.y_b)) <<< 4;
                  b16_in  = (ACC_W'(cmd_ff.x_b) - ACC_W'(cmd_ff.x_a)) <<< 4;
                  x_lo_in = (cmd_ff.x_a < cmd_ff.x_b) ? OFS_W'(cmd_ff.x_a) : OFS_W'(cmd_ff.x_b);
                  x_hi_in = (cmd_ff.x_a < cmd_ff.x_b) ? OFS_W'(cmd_ff.x_b) : OFS_W'(cmd_ff.x_a);
                  y_lo_in = (cmd_ff.y_a < cmd_ff.y_b) ? OFS_W'(cmd_ff.y_a) : OFS_W'(cmd_ff.y_b);
                  y_hi_in = (cmd_ff.y_a < cmd_ff.y_b) ? OFS_W'(cmd_ff.y_b) : OFS_W'(cmd_ff.y_a);
                  step_in = SU_YA2;
               end
               SU_YA2: begin
                  mul_a   = MUL_W'(cmd_ff.y_a);
                  mul_b   = MUL_W'(cmd_ff.y_a);
                  d_in    = ACC_W'(prod_ff);
                  step_in = SU_OUTER;
               end
               SU_OUTER: begin
                  mul_a   = signed'({2'b00, cmd_ff.radius}) + MUL_W'(16);
                  mul_b   = signed'({2'b00, cmd_ff.radius}) + MUL_W'(16);
                  d_in    = d_ff + ACC_W'(prod_ff);
                  drow_in = d_ff + ACC_W'(prod_ff);
                  step_in = SU_INNER;
               end
               SU_INNER: begin
                  mul_a    = signed'({2'b00, cmd_ff.radius}) - MUL_W'(16);
                  mul_b    = signed'({2'b00, cmd_ff.radius}) - MUL_W'(16);
                  outer_in = ACC_W'(prod_ff);
                  step_in  = SU_XAYB;
               end
               SU_XAYB: begin
                  mul_a    = MUL_W'(cmd_ff.x_a);
                  mul_b    = MUL_W'(cmd_ff.y_b);
                  inner_in = ACC_W'(prod_ff);
                  step_in  = SU_XBYA;
               end
               SU_XBYA: begin
                  mul_a   = MUL_W'(cmd_ff.x_b);
                  mul_b   = MUL_W'(cmd_ff.y_a);
                  s_in    = ACC_W'(prod_ff);
                  step_in = SU_LAST;
               end
               SU_LAST: begin
                  s_in     = s_ff - ACC_W'(prod_ff);
                  srow_in  = s_ff - ACC_W'(prod_ff);
                  col_in   = '0;
                  row_in   = '0;
                  addr_in  = '0;
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            mem_we  = covered;
            addr_in = addr_ff + 1'b1;
            if (last_col) begin
               // wrap to column 0 of the next row
               col_in  = '0;
               row_in  = row_ff + 1'b1;
               dx_in   = -OFS_W'(cmd_ff.x_a);
               dy_in   = dy_ff + OFS_W'(16);
               d_in    = drow_next;
               drow_in = drow_next;
               s_in    = srow_next;
               srow_in = srow_next;
               if (last_row) begin
                  state_in = ST_DONE;
               end
            end else begin
               col_in = col_ff + 1'b1;
               dx_in  = dx_ff + OFS_W'(16);
               d_in   = d_ff + (ACC_W'(dx_ff) <<< 5) + UNIT_SQ;
               s_in   = s_ff + a16_ff;
            end
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_READ: begin
            rsp_strobe            = 1'b1;
            rsp_word.is_read      = 1'b1;
            rsp_word.pixel_symbol = rd_ok_ff ? rd_data_ff : '0;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy    = (state_ff != ST_IDLE);
   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      cmd_ff   <= cmd_in;
      rd_ok_ff <= rd_ok_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      prod_ff  <= prod_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      d_ff     <= d_in;
      drow_ff  <= drow_in;
      outer_ff <= outer_in;
      inner_ff <= inner_in;
      s_ff     <= s_in;
      srow_ff  <= srow_in;
      a16_ff   <= a16_in;
      b16_ff   <= b16_in;
      x_lo_ff  <= x_lo_in;
      x_hi_ff  <= x_hi_in;
      y_lo_ff  <= y_lo_in;
      y_hi_ff  <= y_hi_in;
   end

   // canvas: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         canvas_mem[addr_ff] <= mem_wdata;
      end
      rd_data_ff <= canvas_mem[rd_addr];
   end

`ifndef ASSERT_OFF
   a_write_only_clear_or_scan: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_SCAN))
      else $error("canvas written outside clear or scan");

   a_draw_enters_setup: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.opcode != OP_READ) |=> (state_ff == ST_SETUP && step_ff == SU_XA2))
      else $error("draw command did not start setup");

   a_read_answers_next: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.opcode == OP_READ) |=> (rsp_strobe && rsp_word.is_read))
      else $error("read result missing");

   a_draw_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.is_read) |-> (rsp_word.pixel_symbol == 8'd0))
      else $error("draw result carries data");

   a_strobe_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("block not idle after result");
`endif

endmodule
